### rtl/core/ucm_pkg.sv
package ucm_pkg;

  localparam int CODE_W  = 21;
  localparam int DELTA_W = 10;

  typedef logic [CODE_W-1:0]         code_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic [1:0]                order_t;

  typedef enum logic [1:0] {
    CMD_LOWER   = 2'd0,
    CMD_UPPER   = 2'd1,
    CMD_COMPARE = 2'd2
  } cmd_t;

  // two's complement order codes
  localparam order_t ORD_EQUAL   = 2'b00;
  localparam order_t ORD_GREATER = 2'b01;
  localparam order_t ORD_LESS    = 2'b11;

  // block boundaries and exceptions
  localparam code_t CP_LATIN1_UC   = 21'h0000C0;
  localparam code_t CP_DOTTED_I    = 21'h000130;
  localparam code_t CP_DOTLESS_I   = 21'h000131;
  localparam code_t CP_Y_DIAER_UC  = 21'h000178;
  localparam code_t CP_Y_DIAER_LC  = 21'h0000FF;
  localparam code_t CP_LONG_S      = 21'h00017F;
  localparam code_t CP_EXT_B_LO    = 21'h000200;
  localparam code_t CP_CYR_IO      = 21'h000401;
  localparam code_t CP_ARM_UC      = 21'h000531;
  localparam code_t CP_ARM_LC      = 21'h000561;
  localparam code_t CP_ARM_LIG     = 21'h000587;
  localparam code_t CP_GEO_UC      = 21'h0010A0;
  localparam code_t CP_FW_UC       = 21'h00FF21;
  localparam code_t CP_FW_LC       = 21'h00FF41;

  // offset that takes c to its lower-case form
  function automatic delta_t lower_delta(code_t c);
    delta_t d;
    d = '0;
    if (c inside {[21'h41:21'h5A]}) begin
      d = 10'sd32;
    end else if (c < CP_LATIN1_UC) begin
      d = '0;
    end else if (c inside {[CP_LATIN1_UC:21'hD6], [21'hD8:21'hDE]}) begin
      d = 10'sd32;
    end else if (c inside {[21'h100:21'h137], [21'h14A:21'h177]}) begin
      if (c == CP_DOTTED_I) begin
        d = -10'sd199;
      end else if (!c[0]) begin
        d = 10'sd1;
      end
    end else if (c == CP_Y_DIAER_UC) begin
      d = -10'sd121;
    end else if (c inside {[21'h139:21'h148], [21'h179:21'h17E]}) begin
      if (c[0]) begin
        d = 10'sd1;
      end
    end else if (c inside {[CP_EXT_B_LO:21'h217]}) begin
      if (!c[0]) begin
        d = 10'sd1;
      end
    end else if (c inside {[CP_CYR_IO:21'h40C], [21'h40E:21'h40F]}) begin
      d = 10'sd80;
    end else if (c inside {[21'h410:21'h42F]}) begin
      d = 10'sd32;
    end else if (c inside {[21'h460:21'h47F]}) begin
      if (!c[0]) begin
        d = 10'sd1;
      end
    end else if (c inside {[CP_ARM_UC:21'h556]}) begin
      d = 10'sd48;
    end else if (c inside {[CP_GEO_UC:21'h10C5]}) begin
      d = 10'sd48;
    end else if (c inside {[CP_FW_UC:21'hFF3A]}) begin
      d = 10'sd32;
    end
    return d;
  endfunction

  // offset that takes c to its upper-case form
  function automatic delta_t upper_delta(code_t c);
    delta_t d;
    d = '0;
    if (c inside {[21'h61:21'h7A]}) begin
      d = -10'sd32;
    end else if (c < 21'hE0) begin
      d = '0;
    end else if (c inside {[21'hE0:21'hF6], [21'hF8:21'hFE]}) begin
      d = -10'sd32;
    end else if (c == CP_Y_DIAER_LC) begin
      d = 10'sd121;
    end else if (c inside {[21'h100:21'h137], [21'h14A:21'h177]}) begin
      if (c == CP_DOTLESS_I) begin
        d = -10'sd232;
      end else if (c[0]) begin
        d = -10'sd1;
      end
    end else if (c inside {[21'h139:21'h148], [21'h179:21'h17E]}) begin
      if (!c[0]) begin
        d = -10'sd1;
      end
    end else if (c == CP_LONG_S) begin
      d = -10'sd300;
    end else if (c inside {[CP_EXT_B_LO:21'h217]}) begin
      if (c[0]) begin
        d = -10'sd1;
      end
    end else if (c inside {[21'h430:21'h44F]}) begin
      d = -10'sd32;
    end else if (c inside {[21'h451:21'h45C], [21'h45E:21'h45F]}) begin
      d = -10'sd80;
    end else if (c inside {[21'h460:21'h47F]}) begin
      if (c[0]) begin
        d = -10'sd1;
      end
    end else if (c >= CP_ARM_LC && c < CP_ARM_LIG) begin
      d = -10'sd48;
    end else if (c inside {[CP_FW_LC:21'hFF5A]}) begin
      d = -10'sd32;
    end
    return d;
  endfunction

  function automatic code_t apply_delta(code_t c, delta_t d);
    return code_t'(c + {{(CODE_W-DELTA_W){d[DELTA_W-1]}}, d});
  endfunction

endpackage

### rtl/core/ucm_if.sv
interface ucm_in_if;
  import ucm_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  code_t      code_a;
  code_t      code_b;

  modport source (output valid, cmd, code_a, code_b, input ready);
  modport sink   (input valid, cmd, code_a, code_b, output ready);
endinterface

interface ucm_out_if;
  import ucm_pkg::*;

  logic   valid;
  logic   ready;
  code_t  mapped;
  order_t order;
  logic   equal;

  modport source (output valid, mapped, order, equal, input ready);
  modport sink   (input valid, mapped, order, equal, output ready);
endinterface

### rtl/core/unicode_case_map_compare_core.sv
// An accepted item loads the classify, offset-add and result registers in turn.
// Throughput: 1 item per cycle unless out_ch.ready stalls it, set by the three-stage
//   pipeline (classify, offset add, compare); each stage advances whenever it is empty
//   or the stage after it moves. Reset: rst_n synchronous, active low; clears the
//   stage valid bits only, payload registers are not reset.
module unicode_case_map_compare_core (
  input  logic         clk,
  input  logic         rst_n,
  ucm_in_if.sink       in_ch,
  ucm_out_if.source    out_ch
);
  import ucm_pkg::*;

  // ---------------------------------------------------------------------------
  // Stage enables. A stage loads when it is empty or its content moves on,
  // so a stall at the output backs up stage by stage without losing items.
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r;
  logic s1_en, s2_en, s3_en;

  assign s3_en = !s3_valid_r || out_ch.ready;
  assign s2_en = !s2_valid_r || s3_en;
  assign s1_en = !s1_valid_r || s2_en;

  assign in_ch.ready = s1_en;

  // ---------------------------------------------------------------------------
  // Stage 1: range classification. Each operand gets a signed offset; the
  // first operand's offset follows the command (upper for CMD_UPPER, none for
  // the unused code, lower otherwise).
  // ---------------------------------------------------------------------------
  logic [1:0] s1_cmd_r;
  code_t      s1_a_r, s1_b_r;
  delta_t     s1_da_r, s1_db_r;
  delta_t     s1_da_nxt, s1_db_nxt;

  always_comb begin
    case (in_ch.cmd)
      CMD_LOWER:   s1_da_nxt = lower_delta(in_ch.code_a);
      CMD_UPPER:   s1_da_nxt = upper_delta(in_ch.code_a);
      CMD_COMPARE: s1_da_nxt = lower_delta(in_ch.code_a);
      default:     s1_da_nxt = '0;  // unused command: pass code_a through
    endcase
    s1_db_nxt = lower_delta(in_ch.code_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_cmd_r <= in_ch.cmd;
      s1_a_r   <= in_ch.code_a;
      s1_b_r   <= in_ch.code_b;
      s1_da_r  <= s1_da_nxt;
      s1_db_r  <= s1_db_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: apply the offsets. Offsets are only nonzero inside mapped
  // ranges, so the 21-bit add never wraps.
  // ---------------------------------------------------------------------------
  logic [1:0] s2_cmd_r;
  code_t      s2_ma_r, s2_lb_r;
  code_t      s2_ma_nxt, s2_lb_nxt;

  assign s2_ma_nxt = apply_delta(s1_a_r, s1_da_r);
  assign s2_lb_nxt = apply_delta(s1_b_r, s1_db_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_cmd_r <= s1_cmd_r;
      s2_ma_r  <= s2_ma_nxt;
      s2_lb_r  <= s2_lb_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: compare the lowered operands and form the result. This is the
  // output register; order and equal stay zero unless the item is a compare.
  // ---------------------------------------------------------------------------
  code_t  s3_mapped_r;
  order_t s3_order_r, s3_order_nxt;
  logic   s3_equal_r, s3_equal_nxt;

  always_comb begin
    s3_order_nxt = ORD_EQUAL;
    s3_equal_nxt = 1'b0;
    if (s2_cmd_r == CMD_COMPARE) begin
      if (s2_ma_r > s2_lb_r) begin
        s3_order_nxt = ORD_GREATER;
      end else if (s2_ma_r < s2_lb_r) begin
        s3_order_nxt = ORD_LESS;
      end else begin
        s3_equal_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_mapped_r <= s2_ma_r;
      s3_order_r  <= s3_order_nxt;
      s3_equal_r  <= s3_equal_nxt;
    end
  end

  assign out_ch.valid  = s3_valid_r;
  assign out_ch.mapped = s3_mapped_r;
  assign out_ch.order  = s3_order_r;
  assign out_ch.equal  = s3_equal_r;

endmodule

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ucm_pkg::*;

  // cmd encoding 3 is not part of cmd_t; the block passes code_a straight through
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam int unsigned N_RANDOM   = 1100;
  localparam int unsigned STALL_PCT  = 19;
  // no idling on either side while the sent or checked item count is in this window
  localparam int unsigned STEADY_LO  = 400;
  localparam int unsigned STEADY_HI  = 650;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [1:0] cmd;
    code_t      code_a;
    code_t      code_b;
    bit         drain_first;  // hold this item until every result is back
  } case_req_t;

  typedef struct packed {
    code_t  mapped;
    order_t order;
    logic   equal;
  } case_result_t;

  logic clk;
  logic rst_n;

  ucm_in_if  in_ch ();
  ucm_out_if out_ch ();

  unicode_case_map_compare_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  case_req_t    req_q [$];           // items waiting to be driven
  case_result_t case_results_q [$];  // results predicted for accepted items

  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_equal_hits;
  int unsigned n_drains;
  int unsigned stuck_cycles;
  int unsigned cmd_count [4];

  // Code points sitting on the edges of the mapping ranges. Over a third of the random
  // picks land on these, give or take two, so every range boundary gets hit.
  code_t boundary_cps [$] = '{
    21'h40, 21'h41, 21'h5A, 21'h5B, 21'h60, 21'h61, 21'h7A, 21'h7B,
    21'hBF, 21'hC0, 21'hD6, 21'hD7, 21'hD8, 21'hDE, 21'hDF, 21'hE0,
    21'hF6, 21'hF7, 21'hF8, 21'hFE, 21'hFF, 21'h100, 21'h130, 21'h131,
    21'h137, 21'h138, 21'h139, 21'h148, 21'h149, 21'h14A, 21'h177, 21'h178,
    21'h179, 21'h17E, 21'h17F, 21'h180, 21'h1FF, 21'h200, 21'h217, 21'h218,
    21'h400, 21'h401, 21'h40C, 21'h40D, 21'h40E, 21'h40F, 21'h410, 21'h42F,
    21'h430, 21'h44F, 21'h450, 21'h451, 21'h45C, 21'h45D, 21'h45E, 21'h45F,
    21'h460, 21'h47F, 21'h480, 21'h530, 21'h531, 21'h556, 21'h557, 21'h560,
    21'h561, 21'h586, 21'h587, 21'h109F, 21'h10A0, 21'h10C5, 21'h10C6, 21'h10D0,
    21'h10F5, 21'hFF20, 21'hFF21, 21'hFF3A, 21'hFF3B, 21'hFF40, 21'hFF41,
    21'hFF5A, 21'hFF5B, 21'h10FFFF, 21'h110000, 21'h1FFFFF
  };

  // ---------------------------------------------------------------------------
  // Case folding tables
  // ---------------------------------------------------------------------------

  // Latin Ext-A pair blocks: upper case on the even code in 0x100-0x137 and
  // 0x14A-0x177, on the odd code in 0x139-0x148 and 0x179-0x17E
  function automatic bit in_ext_a_even_pairs(code_t c);
    return (c >= 21'h100 && c <= 21'h137) || (c >= 21'h14A && c <= 21'h177);
  endfunction

  function automatic bit in_ext_a_odd_pairs(code_t c);
    return (c >= 21'h139 && c <= 21'h148) || (c >= 21'h179 && c <= 21'h17E);
  endfunction

  function automatic code_t cp_to_lower(code_t c);
    code_t r;
    r = c;
    if (c >= 21'h41 && c <= 21'h5A) begin
      r = c + 21'd32;
    end else if ((c >= 21'hC0 && c <= 21'hD6) || (c >= 21'hD8 && c <= 21'hDE)) begin
      r = c + 21'd32;
    end else if (c == 21'h130) begin
      r = 21'h69;                       // dotted capital I folds to plain i
    end else if (in_ext_a_even_pairs(c)) begin
      if (!c[0]) r = c + 21'd1;
    end else if (c == 21'h178) begin
      r = 21'hFF;                       // Y with diaeresis lives back in Latin-1
    end else if (in_ext_a_odd_pairs(c)) begin
      if (c[0]) r = c + 21'd1;
    end else if (c >= 21'h200 && c <= 21'h217) begin
      if (!c[0]) r = c + 21'd1;
    end else if ((c >= 21'h401 && c <= 21'h40C) || (c >= 21'h40E && c <= 21'h40F)) begin
      r = c + 21'd80;
    end else if (c >= 21'h410 && c <= 21'h42F) begin
      r = c + 21'd32;
    end else if (c >= 21'h460 && c <= 21'h47F) begin
      if (!c[0]) r = c + 21'd1;
    end else if (c >= 21'h531 && c <= 21'h556) begin
      r = c + 21'd48;
    end else if (c >= 21'h10A0 && c <= 21'h10C5) begin
      r = c + 21'd48;
    end else if (c >= 21'hFF21 && c <= 21'hFF3A) begin
      r = c + 21'd32;
    end
    return r;
  endfunction

  function automatic code_t cp_to_upper(code_t c);
    code_t r;
    r = c;
    if (c >= 21'h61 && c <= 21'h7A) begin
      r = c - 21'd32;
    end else if ((c >= 21'hE0 && c <= 21'hF6) || (c >= 21'hF8 && c <= 21'hFE)) begin
      r = c - 21'd32;
    end else if (c == 21'hFF) begin
      r = 21'h178;
    end else if (c == 21'h131) begin
      r = 21'h49;                       // dotless i goes up to plain I
    end else if (in_ext_a_even_pairs(c)) begin
      if (c[0]) r = c - 21'd1;
    end else if (in_ext_a_odd_pairs(c)) begin
      if (!c[0]) r = c - 21'd1;
    end else if (c == 21'h17F) begin
      r = 21'h53;                       // long s goes up to S
    end else if (c >= 21'h200 && c <= 21'h217) begin
      if (c[0]) r = c - 21'd1;
    end else if (c >= 21'h430 && c <= 21'h44F) begin
      r = c - 21'd32;
    end else if ((c >= 21'h451 && c <= 21'h45C) || (c >= 21'h45E && c <= 21'h45F)) begin
      r = c - 21'd80;
    end else if (c >= 21'h460 && c <= 21'h47F) begin
      if (c[0]) r = c - 21'd1;
    end else if (c >= 21'h561 && c <= 21'h586) begin
      r = c - 21'd48;                   // ligature at 0x587 has no simple upper
    end else if (c >= 21'hFF41 && c <= 21'hFF5A) begin
      r = c - 21'd32;
    end
    // Georgian has no upper mapping here
    return r;
  endfunction

  function automatic case_result_t predict_case_result(logic [1:0] cmd, code_t a, code_t b);
    case_result_t r;
    code_t        la;
    code_t        lb;
    la = cp_to_lower(a);
    lb = cp_to_lower(b);
    r.mapped = a;
    r.order  = ORD_EQUAL;
    r.equal  = 1'b0;
    case (cmd)
      CMD_LOWER: r.mapped = la;
      CMD_UPPER: r.mapped = cp_to_upper(a);
      CMD_COMPARE: begin
        r.mapped = la;
        if (la > lb) begin
          r.order = ORD_GREATER;
        end else if (la < lb) begin
          r.order = ORD_LESS;
        end else begin
          r.equal = 1'b1;
        end
      end
      default: ;  // reserved command: pass-through, no order
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_req(logic [1:0] cmd, code_t a, code_t b, bit drain);
    case_req_t r;
    r.cmd         = cmd;
    r.code_a      = a;
    r.code_b      = b;
    r.drain_first = drain;
    req_q.push_back(r);
    cmd_count[cmd]++;
  endfunction

  // Mostly the mapped blocks and their edges; a slice of the whole 21-bit
  // space so every code bit toggles, including values past U+10FFFF.
  function automatic code_t pick_code();
    int unsigned sel;
    code_t       c;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      c = boundary_cps[$urandom_range(0, boundary_cps.size() - 1)]
          + code_t'($urandom_range(0, 4)) - code_t'(2);
    end else if (sel < 55) begin
      c = code_t'($urandom_range(0, 'h7F));
    end else if (sel < 75) begin
      c = code_t'($urandom_range(0, 'h5FF));
    end else if (sel < 83) begin
      c = code_t'($urandom_range('h1000, 'h10FF));
    end else if (sel < 90) begin
      c = code_t'($urandom_range('hFF00, 'hFF7F));
    end else if (sel < 95) begin
      c = code_t'($urandom_range(0, 'h10FFFF));
    end else begin
      c = code_t'($urandom());
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Driver: pops the next item when the slot is free. A drain-flagged item
  // is held back until every accepted item has produced its result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_items
    int unsigned sent_now;
    bit          gap;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      sent_now = n_sent;
      if (in_ch.valid && in_ch.ready) begin
        case_results_q.push_back(
          predict_case_result(in_ch.cmd, in_ch.code_a, in_ch.code_b));
        sent_now = n_sent + 1;
        n_sent <= sent_now;
      end
      if (!in_ch.valid || in_ch.ready) begin
        gap = !(sent_now >= STEADY_LO && sent_now < STEADY_HI)
              && ($urandom_range(0, 99) < STALL_PCT);
        // n_checked is last edge's value, so a drain waits until the final result is counted
        if (req_q.size() != 0 && !gap
            && !(req_q[0].drain_first && n_checked != sent_now)) begin
          in_ch.valid  <= 1'b1;
          in_ch.cmd    <= req_q[0].cmd;
          in_ch.code_a <= req_q[0].code_a;
          in_ch.code_b <= req_q[0].code_b;
          if (req_q[0].drain_first) n_drains <= n_drains + 1;
          void'(req_q.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted result is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    case_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_checked <= n_checked + 1;
        if (out_ch.equal === 1'b1) n_equal_hits <= n_equal_hits + 1;
        if (case_results_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("[%0t] unexpected result: mapped %h order %b equal %b",
                     $realtime, out_ch.mapped, out_ch.order, out_ch.equal);
        end else begin
          want = case_results_q.pop_front();
          if (want.mapped !== out_ch.mapped || want.order !== out_ch.order
              || want.equal !== out_ch.equal) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("[%0t] result %0d wrong: mapped exp %h got %h, order exp %b got %b, equal exp %b got %b",
                       $realtime, n_checked, want.mapped, out_ch.mapped,
                       want.order, out_ch.order, want.equal, out_ch.equal);
          end
        end
      end
      out_ch.ready <= (n_checked >= STEADY_LO && n_checked < STEADY_HI)
                      || ($urandom_range(0, 99) >= STALL_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a run that moves nothing for too long is hung.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
                 stuck_cycles, case_results_q.size());
        $display("FAILURE");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    logic [1:0]  op;
    code_t       a;
    code_t       b;
    int unsigned sel;
    bit          drain;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_LOWER;
    in_ch.code_a = '0;
    in_ch.code_b = '0;
    out_ch.ready = 1'b0;
    n_sent       = 0;
    n_checked    = 0;
    n_errors     = 0;
    n_equal_hits = 0;
    n_drains     = 0;
    stuck_cycles = 0;
    foreach (cmd_count[i]) cmd_count[i] = 0;

    // directed: field extremes, every command, the single exceptions
    queue_req(CMD_LOWER,    21'h000000, 21'h000000, 1'b0);
    queue_req(CMD_UPPER,    21'h1FFFFF, 21'h1FFFFF, 1'b0);  // beyond code space
    queue_req(CMD_LOWER,    21'h1FFFFF, 21'h000000, 1'b0);
    queue_req(CMD_COMPARE,  21'h000000, 21'h1FFFFF, 1'b0);  // less
    queue_req(CMD_COMPARE,  21'h1FFFFF, 21'h000000, 1'b0);  // greater
    queue_req(CMD_COMPARE,  21'h000041, 21'h000061, 1'b0);  // A vs a
    queue_req(CMD_LOWER,    CP_DOTTED_I, 21'h0, 1'b0);
    queue_req(CMD_UPPER,    CP_DOTLESS_I, 21'h0, 1'b0);
    queue_req(CMD_COMPARE,  CP_DOTTED_I, 21'h000049, 1'b0); // both fold to i
    queue_req(CMD_LOWER,    CP_Y_DIAER_UC, 21'h0, 1'b0);
    queue_req(CMD_UPPER,    CP_Y_DIAER_LC, 21'h0, 1'b0);
    queue_req(CMD_UPPER,    CP_LONG_S, 21'h0, 1'b0);
    queue_req(CMD_LOWER,    CP_LONG_S, 21'h0, 1'b0);
    queue_req(CMD_RESERVED, 21'h000041, 21'h1FFFFF, 1'b0);
    queue_req(CMD_LOWER,    CP_CYR_IO, 21'h0, 1'b0);
    queue_req(CMD_UPPER,    21'h000451, 21'h0, 1'b0);
    queue_req(CMD_LOWER,    21'h00040D, 21'h0, 1'b0);       // gap in Cyrillic
    queue_req(CMD_LOWER,    CP_ARM_UC, 21'h0, 1'b0);
    queue_req(CMD_UPPER,    21'h000586, 21'h0, 1'b0);
    queue_req(CMD_UPPER,    CP_ARM_LIG, 21'h0, 1'b0);
    queue_req(CMD_LOWER,    CP_GEO_UC, 21'h0, 1'b0);
    queue_req(CMD_UPPER,    21'h0010D0, 21'h0, 1'b0);       // Georgian stays put
    queue_req(CMD_LOWER,    CP_FW_UC, 21'h0, 1'b0);
    queue_req(CMD_UPPER,    21'h00FF5A, 21'h0, 1'b0);
    queue_req(CMD_LOWER,    CP_EXT_B_LO, 21'h1FFFFF, 1'b0);
    queue_req(CMD_UPPER,    21'h000217, 21'h0, 1'b0);
    queue_req(CMD_COMPARE,  21'h10FFFF, 21'h110000, 1'b0);

    // random: compares lean on case partners so equal actually fires
    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30)      op = CMD_LOWER;
      else if (sel < 60) op = CMD_UPPER;
      else if (sel < 95) op = CMD_COMPARE;
      else               op = CMD_RESERVED;
      a = pick_code();
      b = code_t'($urandom());
      if (op == CMD_COMPARE) begin
        case ($urandom_range(0, 7))
          0: b = cp_to_upper(a);
          1: b = cp_to_lower(a);
          2: b = a;
          3: b = cp_to_upper(cp_to_lower(a));
          default: b = pick_code();
        endcase
      end
      // drain the pipe after the directed part, at items 300 and 800, and now and then at random
      drain = (i == 0) || (i == 300) || (i == 800) || ($urandom_range(0, 199) == 0);
      queue_req(op, a, b, drain);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_ch.valid || case_results_q.size() != 0)
      @(posedge clk);
    // wait past the pipeline depth to catch stray results
    repeat (20) @(posedge clk);

    $display("covered %0d lower, %0d upper, %0d compare and %0d reserved-command items",
             cmd_count[CMD_LOWER], cmd_count[CMD_UPPER], cmd_count[CMD_COMPARE],
             cmd_count[CMD_RESERVED]);
    $display("%0d results checked, %0d compares equal, %0d pipeline drains, %0d errors",
             n_checked, n_equal_hits, n_drains, n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/ucm_pkg.sv
rtl/core/ucm_if.sv
rtl/core/unicode_case_map_compare_core.sv
bench/tb.sv
